// File: rtl/core/sis_pkg.sv
// Shared types and constants for the small integer set block.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sis_pkg;

    // Number of entries in the member store.
    localparam int CAPACITY  = 16;
    // Bits of a store address, and of a counter that can hold CAPACITY itself.
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 2;
    localparam int OUT_CNT_W = 5;

    // Request kinds; the unused code behaves as a query.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a request and restart the scan
        logic scan;       // read the next entry and compare the previous one
        logic read_last;  // read the last member, to refill a removed slot
        logic finish;     // update the store and count, write the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;          // the entry under comparison matches the value
        logic exhausted;    // every member has been compared without a match
        logic kind_remove;  // the captured request is a remove
        logic out_busy;     // the result register is full and not being taken
    } t_status;

endpackage

// File: rtl/core/sis_ctrl.sv
// Controller state machine for the small integer set block.
// Depends on sis_pkg; drives the command struct of sis_datapath.
`timescale 1ns / 1ps

module sis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sis_pkg::t_status i_status,
    output sis_pkg::t_cmd    o_cmd
);
    import sis_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit && i_status.kind_remove) begin
                    n_state = S_LAST;
                end else if (i_status.hit || i_status.exhausted) begin
                    n_state = S_FIN;
                end
            end
            S_LAST: begin
                o_cmd.read_last = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/sis_datapath.sv
// Datapath of the small integer set block: member store, scan pointer, count and result register.
// Depends on sis_pkg; commanded by sis_ctrl.
`timescale 1ns / 1ps

module sis_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sis_pkg::t_cmd                   i_cmd,
    output sis_pkg::t_status                o_status,
    input  logic [sis_pkg::KIND_W-1:0]      i_in_kind,
    input  logic signed [sis_pkg::VALUE_W-1:0] i_in_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_was_present,
    output logic                            o_rejected_full,
    output logic [sis_pkg::OUT_CNT_W-1:0]   o_count
);
    import sis_pkg::*;

    logic [VALUE_W-1:0] r_mem [CAPACITY];

    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_valid;
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_found;
    logic [IDX_W-1:0]   r_slot;

    logic               r_out_valid;
    logic               r_out_present;
    logic               r_out_rejected;
    logic [OUT_CNT_W-1:0] r_out_count;

    logic hit;
    logic is_insert;
    logic is_remove;
    logic has_room;
    logic do_add;
    logic do_del;
    logic [CNT_W-1:0] last_pos;

    assign hit       = r_cmp_valid && (r_rd_data == r_value);
    assign is_insert = (r_kind == KIND_INSERT);
    assign is_remove = (r_kind == KIND_REMOVE);
    assign has_room  = (r_count < CNT_W'(CAPACITY));
    assign do_add    = is_insert && !r_found && has_room;
    assign do_del    = is_remove && r_found;
    assign last_pos  = r_count - CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (do_add) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_del) begin
            n_count = last_pos;
        end
    end

    assign o_status.hit         = hit;
    assign o_status.exhausted   = !r_cmp_valid && (r_idx >= r_count);
    assign o_status.kind_remove = is_remove;
    assign o_status.out_busy    = r_out_valid && !i_out_ready;

    // Store: one read address and one write address a cycle, read data registered.
    // A removed slot is refilled with the last member, since order is not visible.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (r_idx < r_count)) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end else if (i_cmd.read_last) begin
            r_rd_data <= r_mem[last_pos[IDX_W-1:0]];
        end
        if (i_cmd.finish && do_add) begin
            r_mem[r_count[IDX_W-1:0]] <= r_value;
        end else if (i_cmd.finish && do_del) begin
            r_mem[r_slot] <= r_rd_data;
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_kind;
            r_value <= i_in_value;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_idx < r_count) begin
                r_cmp_idx <= r_idx[IDX_W-1:0];
                r_idx     <= r_idx + CNT_W'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
                r_slot  <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_valid <= (r_idx < r_count);
        end else if (i_cmd.load || i_cmd.read_last) begin
            r_cmp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_present  <= r_found;
            r_out_rejected <= is_insert && !r_found && !has_room;
            r_out_count    <= OUT_CNT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_was_present   = r_out_present;
    assign o_rejected_full = r_out_rejected;
    assign o_count         = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("member count exceeds capacity");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_out_valid && !i_out_ready))
        else $error("result written over an untaken result");

    a_count_changes_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_count))
        else $error("member count changed outside a finish step");

    a_remove_hit_has_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && do_del) |-> (r_count != '0))
        else $error("remove of a found member with an empty store");

endmodule

// File: rtl/core/small_integer_set_top.sv
// Top level of the small integer set block: stream ports, controller and datapath.
// Depends on sis_pkg, sis_ctrl and sis_datapath.
`timescale 1ns / 1ps

// The block holds a set of up to CAPACITY distinct 32-bit integers and serves
// one request per input item on the slave stream. The request kind travels in
// tuser (0 insert, 1 remove, 2 query; 3 behaves as a query) and the value in
// tdata. Every request yields exactly one item on the master stream, carrying
// whether the value was present beforehand, whether an insert was refused
// because the store was full, and the member count after the request.
//
// After an item is accepted, the scan compares the stored members in order, from
// position zero, until the value is found or every member has been compared; an
// empty set is not scanned. A remove that finds its value takes one more step,
// to read the last member that refills the freed slot. The controller is ready
// for the next item only after a result is written, so items do not overlap.
// The scan time is set by the single read port of the member store, which the
// scan walks one entry a cycle.
//
// Reset empties the set at once; the store itself is not cleared, since only
// entries below the count are ever read. The result sits in an output register,
// so the next item is accepted while a result still waits; if the receiver
// stalls, the following request is scanned but held before its result until
// the register is taken.

module small_integer_set_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] was_present, [1] rejected_full,
                                          // [6:2] count, [7] zero
);
    import sis_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic                 was_present;
    logic                 rejected_full;
    logic [OUT_CNT_W-1:0] count;

    // Controller: sequences accept, scan, refill read and result write.
    sis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: member store, scan comparison, count and result register.
    sis_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_in_kind       (i_s_axis_tuser),
        .i_in_value      (i_s_axis_tdata),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_was_present   (was_present),
        .o_rejected_full (rejected_full),
        .o_count         (count)
    );

    // Result fields packed from the lowest bit up, padded to a whole byte.
    assign o_m_axis_tdata = {1'b0, count, rejected_full, was_present};

endmodule
